// ----- src/uapq_pkg.sv -----
// shared types and constants of the unsorted-array priority queue
// no dependencies; used by uapq_scan and unsorted_array_priority_queue
package uapq_pkg;

   localparam int MAX_ENTRIES_DEF  = 16;
   localparam int PAYLOAD_BITS_DEF = 32;
   localparam int KEY_BITS         = 32;
   localparam int FIELD_BITS       = 32;
   localparam int CAP_BITS         = 5;
   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXTRACT = 1'b1;

   typedef struct packed {
      logic                         operation;
      logic signed [KEY_BITS-1:0]   key;
      logic        [FIELD_BITS-1:0] payload;
   } req_type;

   typedef struct packed {
      logic signed [KEY_BITS-1:0]   out_key;
      logic        [FIELD_BITS-1:0] out_payload;
      logic                         item_valid;
      logic                         error;
      logic                         is_empty;
      logic                         is_full;
   } rsp_type;

   // controls from the sequencer to the scan unit
   typedef struct packed {
      logic clear;  // new extract starts
      logic hit;    // read data of one entry is present
      logic last;   // that entry is the last one in use
   } scan_ctl_type;

endpackage

// ----- src/uapq_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no package dependencies
module uapq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- src/uapq_scan.sv -----
// max-key tracker fed one stored entry per cycle from the ram read port
// depends on uapq_pkg
module uapq_scan #(
   parameter int MAX_ENTRIES  = uapq_pkg::MAX_ENTRIES_DEF,
   parameter int PAYLOAD_BITS = uapq_pkg::PAYLOAD_BITS_DEF,
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1,
   localparam int EW = uapq_pkg::KEY_BITS + PAYLOAD_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  uapq_pkg::scan_ctl_type ctl,
   input  logic [IW-1:0]          hit_idx,
   input  logic [EW-1:0]          hit_entry,
   output logic [IW-1:0]          best_idx,
   output logic [EW-1:0]          best_entry,
   output logic [EW-1:0]          last_entry
);

   logic          have_best_ff, have_best_in;
   logic [IW-1:0] best_idx_ff,  best_idx_in;
   logic [EW-1:0] best_entry_ff, best_entry_in;
   logic [EW-1:0] last_entry_ff, last_entry_in;
   logic signed [uapq_pkg::KEY_BITS-1:0] best_key;
   logic signed [uapq_pkg::KEY_BITS-1:0] hit_key;
   logic          take;

   assign best_key = best_entry_ff[EW-1 -: uapq_pkg::KEY_BITS];
   assign hit_key  = hit_entry[EW-1 -: uapq_pkg::KEY_BITS];
   // strictly greater only, so the lowest index wins a tie
   assign take = ctl.hit && (!have_best_ff || (best_key < hit_key));

   always_comb begin
      have_best_in  = have_best_ff;
      best_idx_in   = best_idx_ff;
      best_entry_in = best_entry_ff;
      last_entry_in = last_entry_ff;
      if (ctl.clear) begin
         have_best_in = 1'b0;
      end else if (take) begin
         have_best_in  = 1'b1;
         best_idx_in   = hit_idx;
         best_entry_in = hit_entry;
      end
      if (ctl.hit && ctl.last) begin
         last_entry_in = hit_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_best_ff <= 1'b0;
      end else begin
         have_best_ff <= have_best_in;
      end
      best_idx_ff   <= best_idx_in;
      best_entry_ff <= best_entry_in;
      last_entry_ff <= last_entry_in;
   end

   assign best_idx   = best_idx_ff;
   assign best_entry = best_entry_ff;
   assign last_entry = last_entry_ff;

endmodule

// ----- src/unsorted_array_priority_queue.sv -----
// Priority queue held unsorted in one ram of {key, payload} entries. An insert
// writes the entry at the current count. An extract reads the entries in use
// through the single ram read port, one per cycle. The winner is the first
// entry with the largest signed key; the last entry is moved into its place.
// One item is worked on at a time; the result sits in an output register so
// the next item is taken while it waits. No clearing pass after reset.
// depends on uapq_pkg, uapq_ram and uapq_scan
module unsorted_array_priority_queue #(
   parameter int MAX_ENTRIES  = uapq_pkg::MAX_ENTRIES_DEF,
   parameter int PAYLOAD_BITS = uapq_pkg::PAYLOAD_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  uapq_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output uapq_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [uapq_pkg::CAP_BITS-1:0]       csr_data
);

   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int KB = uapq_pkg::KEY_BITS;
   localparam int FB = uapq_pkg::FIELD_BITS;
   localparam int EW = KB + PAYLOAD_BITS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SWAP,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [uapq_pkg::CAP_BITS-1:0] cap_ff, cap_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  last_ff, last_in;
   logic [CW-1:0]  rd_idx_ff, rd_idx_in;
   logic           rd_vld_ff, rd_vld_in;
   logic [IW-1:0]  cmp_idx_ff, cmp_idx_in;
   logic signed [KB-1:0] pend_key_ff, pend_key_in;
   logic [FB-1:0]  pend_pay_ff, pend_pay_in;
   logic           pend_item_ff, pend_item_in;
   logic           pend_err_ff, pend_err_in;
   logic           rsp_valid_ff, rsp_valid_in;
   uapq_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [CW-1:0]  cap_eff;
   logic           is_full;
   logic           accept;
   logic           ins_ok;
   logic           ram_we, ram_re;
   logic [IW-1:0]  ram_wr_addr;
   logic [EW-1:0]  ram_wr_data;
   logic [EW-1:0]  ram_rd_data;
   logic [63:0]    in_pay_wide;
   logic [63:0]    best_pay_wide;
   uapq_pkg::scan_ctl_type scan_ctl;
   logic [IW-1:0]  best_idx;
   logic [EW-1:0]  best_entry;
   logic [EW-1:0]  last_entry;

   // capacity above the array size saturates
   assign cap_eff = (32'(cap_ff) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(cap_ff);
   assign is_full = (count_ff >= cap_eff);

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign ins_ok    = accept && (req_data.operation == uapq_pkg::OP_INSERT) && !is_full;
   assign csr_ready = 1'b1;

   assign in_pay_wide   = 64'(req_data.payload);
   assign best_pay_wide = 64'(best_entry[PAYLOAD_BITS-1:0]);

   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      count_in     = count_ff;
      last_in      = last_ff;
      rd_idx_in    = rd_idx_ff;
      rd_vld_in    = 1'b0;
      cmp_idx_in   = rd_idx_ff[IW-1:0];
      pend_key_in  = pend_key_ff;
      pend_pay_in  = pend_pay_ff;
      pend_item_in = pend_item_ff;
      pend_err_in  = pend_err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_wr_addr  = count_ff[IW-1:0];
      ram_wr_data  = {req_data.key, in_pay_wide[PAYLOAD_BITS-1:0]};
      scan_ctl     = '0;

      if (csr_valid) begin
         cap_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pend_key_in  = '0;
               pend_pay_in  = '0;
               pend_item_in = 1'b0;
               pend_err_in  = 1'b0;
               state_in     = ST_DONE;
               if (req_data.operation == uapq_pkg::OP_INSERT) begin
                  if (is_full) begin
                     pend_err_in = 1'b1;
                  end else begin
                     ram_we   = 1'b1;
                     count_in = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  pend_err_in = 1'b1;
               end else begin
                  last_in        = count_ff - CW'(1);
                  rd_idx_in      = '0;
                  scan_ctl.clear = 1'b1;
                  state_in       = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            ram_re = (rd_idx_ff <= last_ff);
            if (ram_re) begin
               rd_idx_in = rd_idx_ff + CW'(1);
            end
            rd_vld_in     = ram_re;
            scan_ctl.hit  = rd_vld_ff;
            scan_ctl.last = rd_vld_ff && (cmp_idx_ff == last_ff[IW-1:0]);
            if (scan_ctl.last) begin
               state_in = ST_SWAP;
            end
         end
         ST_SWAP: begin
            // last entry fills the hole; its old slot beyond count is never read again
            ram_we       = 1'b1;
            ram_wr_addr  = best_idx;
            ram_wr_data  = last_entry;
            count_in     = last_ff;
            pend_key_in  = best_entry[EW-1 -: KB];
            pend_pay_in  = best_pay_wide[FB-1:0];
            pend_item_in = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.out_key     = pend_key_ff;
               rsp_data_in.out_payload = pend_pay_ff;
               rsp_data_in.item_valid  = pend_item_ff;
               rsp_data_in.error       = pend_err_ff;
               rsp_data_in.is_empty    = (count_ff == '0);
               rsp_data_in.is_full     = is_full;
               state_in                = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= uapq_pkg::CAP_RESET;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff      <= last_in;
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      pend_key_ff  <= pend_key_in;
      pend_pay_ff  <= pend_pay_in;
      pend_item_ff <= pend_item_in;
      pend_err_ff  <= pend_err_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   uapq_ram #(
      .WIDTH (EW),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_re),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (ram_rd_data)
   );

   uapq_scan #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .hit_idx    (cmp_idx_ff),
      .hit_entry  (ram_rd_data),
      .best_idx   (best_idx),
      .best_entry (best_entry),
      .last_entry (last_entry)
   );

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_ENTRIES)
      else $error("entry count beyond array size");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      ins_ok |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("accepted insert did not grow the count");

   a_read_in_range: assert property (@(posedge clock) disable iff (reset)
      ram_re |-> (rd_idx_ff <= last_ff) && (last_ff < count_ff))
      else $error("scan read outside the entries in use");

   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.item_valid && rsp_data_ff.error))
      else $error("result both extracted and in error");
`endif

endmodule
